@@ hdl/tsi_pkg.sv @@
`timescale 1ns / 1ps
package tsi_pkg;

	// defaults for the top level parameters
	localparam int DEF_STACK_DEPTH  = 32;
	localparam int DEF_PALETTE_SIZE = 8;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_DEGREES      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_SYMBOL_DRAWS = 2'd2;

	// configuration reset values
	localparam logic [7:0] TURN_DEGREES_RST      = 8'd60;
	localparam logic [7:0] STEP_LENGTH_RST       = 8'd10;
	localparam logic       MOVE_SYMBOL_DRAWS_RST = 1'b0;

	// symbol codes, ascii
	localparam logic [7:0] SYM_DRAW   = 8'h46; // F
	localparam logic [7:0] SYM_MOVE   = 8'h47; // G
	localparam logic [7:0] SYM_LEFT   = 8'h2B; // +
	localparam logic [7:0] SYM_RIGHT  = 8'h2D; // -
	localparam logic [7:0] SYM_COLOUR = 8'h3E; // >
	localparam logic [7:0] SYM_PUSH   = 8'h5B; // [
	localparam logic [7:0] SYM_POP    = 8'h5D; // ]

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_HALT = 2'd2;

	localparam int HEADING_W = 9;
	localparam logic [HEADING_W-1:0] FULL_TURN  = 9'd360;
	localparam logic [HEADING_W-1:0] HALF_TURN  = 9'd180;
	localparam logic [HEADING_W-1:0] QUART_TURN = 9'd90;
	localparam logic [HEADING_W-1:0] THREE_QUART_TURN = 9'd270;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef logic [14:0] qsin_tab_t [0:90];

	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} stack_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} stack_flags_t;

	typedef struct packed {
		logic               drawn;
		logic signed [31:0] seg_x0;
		logic signed [31:0] seg_y0;
		logic signed [31:0] seg_x1;
		logic signed [31:0] seg_y1;
		logic [2:0]         seg_colour;
		logic [1:0]         status;
	} seg_res_t;

	// quarter wave sine in unsigned q1.14, taylor series in q30 rounded half up
	function automatic qsin_tab_t qsin_build();
		qsin_tab_t          tab;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        r;
		for (int d = 0; d <= 90; d++) begin
			x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
			x2   = (x * x) >> 30;
			term = x;
			sum  = signed'(x);
			term = ((term * x2) >> 30) / 64'd6;
			sum  = sum - signed'(term);
			term = ((term * x2) >> 30) / 64'd20;
			sum  = sum + signed'(term);
			term = ((term * x2) >> 30) / 64'd42;
			sum  = sum - signed'(term);
			term = ((term * x2) >> 30) / 64'd72;
			sum  = sum + signed'(term);
			term = ((term * x2) >> 30) / 64'd110;
			sum  = sum - signed'(term);
			term = ((term * x2) >> 30) / 64'd156;
			sum  = sum + signed'(term);
			term = ((term * x2) >> 30) / 64'd210;
			sum  = sum - signed'(term);
			r    = unsigned'(sum) + 64'd32768;
			tab[d] = r[30:16];
		end
		return tab;
	endfunction

	localparam qsin_tab_t QSIN_TABLE = qsin_build();

	// full wave sine in q2.14 for a heading of 0..359 degrees
	function automatic logic signed [15:0] sine_q14(input logic [HEADING_W-1:0] d);
		logic [HEADING_W-1:0] idx;
		logic                 neg;
		logic [14:0]          mag;
		if (d <= QUART_TURN) begin
			idx = d;
			neg = 1'b0;
		end else if (d <= HALF_TURN) begin
			idx = HALF_TURN - d;
			neg = 1'b0;
		end else if (d <= THREE_QUART_TURN) begin
			idx = d - HALF_TURN;
			neg = 1'b1;
		end else begin
			idx = FULL_TURN - d;
			neg = 1'b1;
		end
		mag = QSIN_TABLE[idx[6:0]];
		return neg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
	endfunction

endpackage

@@ hdl/tsi_if.sv @@
`timescale 1ns / 1ps
interface tsi_sym_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       string_start;

	modport source(output valid, output symbol, output string_start, input ready);
	modport sink(input valid, input symbol, input string_start, output ready);
endinterface

interface tsi_seg_if;
	logic               valid;
	logic               ready;
	logic               drawn;
	logic signed [31:0] seg_x0;
	logic signed [31:0] seg_y0;
	logic signed [31:0] seg_x1;
	logic signed [31:0] seg_y1;
	logic [2:0]         seg_colour;
	logic [1:0]         status;

	modport source(output valid, output drawn, output seg_x0, output seg_y0,
		output seg_x1, output seg_y1, output seg_colour, output status, input ready);
	modport sink(input valid, input drawn, input seg_x0, input seg_y0,
		input seg_x1, input seg_y1, input seg_colour, input status, output ready);
endinterface

@@ hdl/turtle_symbol_interpreter_core.sv @@
`timescale 1ns / 1ps
// a symbol beat is registered in the input stage and its result in the result stage
// throughput: 1 symbol per cycle unless the output stalls; turtle state and the stack
// top live in flops, so a turn, a pop or a move feeds the next symbol in the very next cycle
// the stack below its top entry is a one-port memory with a prefetched read register
// reset (arst_n, async, low): turtle home, stack empty, not halted, registers at defaults
// stack memory contents are not cleared; a pop may prefetch an unwritten word, which is never used
module turtle_symbol_interpreter_core #(
	parameter int STACK_DEPTH  = tsi_pkg::DEF_STACK_DEPTH,
	parameter int PALETTE_SIZE = tsi_pkg::DEF_PALETTE_SIZE
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tsi_sym_if.sink                         symbols,
	tsi_seg_if.source                       segments,
	input  logic                            cfg_we,
	input  logic [tsi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                      cfg_data
);
	localparam int CW      = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
	localparam int ENTRY_W = 64 + tsi_pkg::HEADING_W + CW;

	// configuration registers
	logic [7:0] turn_degrees_q;
	logic [7:0] step_length_q;
	logic       move_symbol_draws_q;

	// input stage and result stage
	logic       valid_s1;
	logic [7:0] symbol_s1;
	logic       string_start_s1;
	logic       valid_s2;
	tsi_pkg::seg_res_t res_s2;

	logic                  out_free;
	logic                  go;
	tsi_pkg::seg_res_t     res;
	tsi_pkg::stack_cmd_t   cmd;
	tsi_pkg::stack_flags_t flags;
	logic [ENTRY_W-1:0]    push_entry;
	logic [ENTRY_W-1:0]    top_entry;

	// result register frees when empty or taken this cycle
	assign out_free      = !valid_s2 || segments.ready;
	// the held symbol is executed when its result has somewhere to go
	assign go            = valid_s1 && out_free;
	assign symbols.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_degrees_q      <= tsi_pkg::TURN_DEGREES_RST;
			step_length_q       <= tsi_pkg::STEP_LENGTH_RST;
			move_symbol_draws_q <= tsi_pkg::MOVE_SYMBOL_DRAWS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tsi_pkg::REG_TURN_DEGREES:      turn_degrees_q      <= cfg_data;
				tsi_pkg::REG_STEP_LENGTH:       step_length_q       <= cfg_data;
				tsi_pkg::REG_MOVE_SYMBOL_DRAWS: move_symbol_draws_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// valid bits of both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (symbols.ready) begin
				valid_s1 <= symbols.valid;
			end
			if (out_free) begin
				valid_s2 <= go;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (symbols.valid && symbols.ready) begin
			symbol_s1       <= symbols.symbol;
			string_start_s1 <= symbols.string_start;
		end
		if (go) begin
			res_s2 <= res;
		end
	end

	tsi_turtle #(
		.PALETTE_SIZE(PALETTE_SIZE),
		.ENTRY_W     (ENTRY_W)
	) u_turtle (
		.clk              (clk),
		.arst_n           (arst_n),
		.go               (go),
		.symbol           (symbol_s1),
		.string_start     (string_start_s1),
		.turn_degrees     (turn_degrees_q),
		.step_length      (step_length_q),
		.move_symbol_draws(move_symbol_draws_q),
		.flags            (flags),
		.pop_entry        (top_entry),
		.cmd              (cmd),
		.push_entry       (push_entry),
		.res              (res)
	);

	tsi_stack #(
		.STACK_DEPTH(STACK_DEPTH),
		.ENTRY_W    (ENTRY_W)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.push_entry(push_entry),
		.flags     (flags),
		.top_entry (top_entry)
	);

	assign segments.valid      = valid_s2;
	assign segments.drawn      = res_s2.drawn;
	assign segments.seg_x0     = res_s2.seg_x0;
	assign segments.seg_y0     = res_s2.seg_y0;
	assign segments.seg_x1     = res_s2.seg_x1;
	assign segments.seg_y1     = res_s2.seg_y1;
	assign segments.seg_colour = res_s2.seg_colour;
	assign segments.status     = res_s2.status;

`ifndef SYNTHESIS
	// an executed symbol always shows up at the output next cycle
	a_go_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> segments.valid)
		else $error("executed symbol did not reach the result register");

	// push and pop are mutually exclusive and only issued on execution
	a_stack_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push || cmd.pop) |-> (go && !(cmd.push && cmd.pop)))
		else $error("bad stack command");

	// a drawn segment never carries an error status
	a_drawn_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(segments.valid && segments.drawn) |-> (segments.status == tsi_pkg::ST_OK))
		else $error("drawn segment with error status");

	// an undrawn result has all segment fields cleared
	a_undrawn_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(segments.valid && !segments.drawn) |->
		(segments.seg_x0 == 0 && segments.seg_y0 == 0 && segments.seg_x1 == 0 &&
		segments.seg_y1 == 0 && segments.seg_colour == 0))
		else $error("undrawn result carries segment data");
`endif
endmodule

@@ hdl/tsi_stack.sv @@
`timescale 1ns / 1ps
module tsi_stack #(
	parameter int STACK_DEPTH = tsi_pkg::DEF_STACK_DEPTH,
	parameter int ENTRY_W     = 76
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tsi_pkg::stack_cmd_t  cmd,
	input  logic [ENTRY_W-1:0]   push_entry,
	output tsi_pkg::stack_flags_t flags,
	output logic [ENTRY_W-1:0]   top_entry
);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// top of stack in flops, the entry below it prefetched from memory
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_eff;
	logic [CNT_W-1:0]   wr_cnt;
	logic [CNT_W-1:0]   rd_cnt;
	logic [ENTRY_W-1:0] top_q;
	logic [ENTRY_W-1:0] below_q;
	logic [ENTRY_W-1:0] mem [STACK_DEPTH];

	assign cnt_eff     = cmd.clear ? '0 : cnt_q;
	assign flags.empty = (cnt_eff == '0);
	assign flags.full  = (cnt_eff == CNT_W'(STACK_DEPTH));
	assign wr_cnt      = cnt_eff - CNT_W'(1);
	assign rd_cnt      = cnt_eff - CNT_W'(3);
	assign top_entry   = top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.push) begin
			cnt_q <= cnt_eff + CNT_W'(1);
		end else if (cmd.pop) begin
			cnt_q <= cnt_eff - CNT_W'(1);
		end else if (cmd.clear) begin
			cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q   <= push_entry;
			below_q <= top_q;
		end else if (cmd.pop) begin
			top_q   <= below_q;
			below_q <= mem[rd_cnt[AW-1:0]];
		end
	end

	// old top spills to memory on a push
	always_ff @(posedge clk) begin
		if (cmd.push && !flags.empty) begin
			mem[wr_cnt[AW-1:0]] <= top_q;
		end
	end
endmodule

@@ hdl/tsi_turtle.sv @@
`timescale 1ns / 1ps
module tsi_turtle #(
	parameter int PALETTE_SIZE = tsi_pkg::DEF_PALETTE_SIZE,
	parameter int ENTRY_W      = 64 + tsi_pkg::HEADING_W +
		((PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic [7:0]            symbol,
	input  logic                  string_start,
	input  logic [7:0]            turn_degrees,
	input  logic [7:0]            step_length,
	input  logic                  move_symbol_draws,
	input  tsi_pkg::stack_flags_t flags,
	input  logic [ENTRY_W-1:0]    pop_entry,
	output tsi_pkg::stack_cmd_t   cmd,
	output logic [ENTRY_W-1:0]    push_entry,
	output tsi_pkg::seg_res_t     res
);
	localparam int CW      = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
	localparam int HW      = tsi_pkg::HEADING_W;

	logic signed [31:0] x_q, y_q, x_e, y_e, x_n, y_n, x_adv, y_adv;
	logic [HW-1:0]      h_q, h_e, h_n, h_cos, h_left, h_right;
	logic [CW-1:0]      col_q, col_e, col_n, col_step;
	logic               halted_q, halted_e, halted_n;
	logic [HW:0]        h_wide;
	logic signed [15:0] cos_v, sin_v;
	logic signed [8:0]  step_s;
	logic signed [24:0] px, py;
	logic signed [22:0] dx, dy;
	logic signed [32:0] sx, sy;

	// string start sends the turtle home before the symbol
	assign x_e      = string_start ? '0 : x_q;
	assign y_e      = string_start ? '0 : y_q;
	assign h_e      = string_start ? '0 : h_q;
	assign col_e    = string_start ? '0 : col_q;
	assign halted_e = string_start ? 1'b0 : halted_q;

	assign h_wide = {1'b0, h_e} + (HW + 1)'(tsi_pkg::QUART_TURN);
	assign h_cos  = (h_wide >= (HW + 1)'(tsi_pkg::FULL_TURN)) ?
		HW'(h_wide - (HW + 1)'(tsi_pkg::FULL_TURN)) : h_wide[HW-1:0];
	assign cos_v  = tsi_pkg::sine_q14(h_cos);
	assign sin_v  = tsi_pkg::sine_q14(h_e);
	assign step_s = signed'({1'b0, step_length});

	// rounded q14 to q12 step, floor((p + 2) / 4)
	assign px = cos_v * step_s + 25'sd2;
	assign py = sin_v * step_s + 25'sd2;
	assign dx = px[24:2];
	assign dy = py[24:2];
	assign sx = 33'(x_e) + 33'(dx);
	assign sy = 33'(y_e) + 33'(dy);

	always_comb begin
		if (sx[32] != sx[31]) begin
			x_adv = sx[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			x_adv = sx[31:0];
		end
		if (sy[32] != sy[31]) begin
			y_adv = sy[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			y_adv = sy[31:0];
		end
	end

	logic [HW:0] h_sum;
	assign h_sum   = {1'b0, h_e} + (HW + 1)'(turn_degrees);
	assign h_right = (h_sum >= (HW + 1)'(tsi_pkg::FULL_TURN)) ?
		HW'(h_sum - (HW + 1)'(tsi_pkg::FULL_TURN)) : h_sum[HW-1:0];
	assign h_left  = (h_e >= HW'(turn_degrees)) ? (h_e - HW'(turn_degrees)) :
		(h_e + tsi_pkg::FULL_TURN - HW'(turn_degrees));
	assign col_step = (col_e == CW'(PALETTE_SIZE - 1)) ? '0 : (col_e + CW'(1));

	assign push_entry = {x_e, y_e, h_e, col_e};

	always_comb begin
		x_n        = x_e;
		y_n        = y_e;
		h_n        = h_e;
		col_n      = col_e;
		halted_n   = halted_e;
		cmd.clear  = go && string_start;
		cmd.push   = 1'b0;
		cmd.pop    = 1'b0;
		res        = '0;
		res.status = tsi_pkg::ST_OK;
		if (halted_e) begin
			res.status = tsi_pkg::ST_HALT;
		end else begin
			case (symbol)
				tsi_pkg::SYM_DRAW, tsi_pkg::SYM_MOVE: begin
					x_n = x_adv;
					y_n = y_adv;
					if (symbol == tsi_pkg::SYM_DRAW || move_symbol_draws) begin
						res.drawn      = 1'b1;
						res.seg_x0     = x_e;
						res.seg_y0     = y_e;
						res.seg_x1     = x_adv;
						res.seg_y1     = y_adv;
						res.seg_colour = 3'(col_e);
					end
				end
				tsi_pkg::SYM_LEFT: begin
					h_n = h_left;
				end
				tsi_pkg::SYM_RIGHT: begin
					h_n = h_right;
				end
				tsi_pkg::SYM_COLOUR: begin
					col_n = col_step;
				end
				tsi_pkg::SYM_PUSH: begin
					if (flags.full) begin
						res.status = tsi_pkg::ST_FULL;
					end else begin
						cmd.push = go;
					end
				end
				tsi_pkg::SYM_POP: begin
					if (flags.empty) begin
						halted_n   = 1'b1;
						res.status = tsi_pkg::ST_HALT;
					end else begin
						cmd.pop = go;
						{x_n, y_n, h_n, col_n} = pop_entry;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			h_q      <= '0;
			col_q    <= '0;
			halted_q <= 1'b0;
		end else if (go) begin
			x_q      <= x_n;
			y_q      <= y_n;
			h_q      <= h_n;
			col_q    <= col_n;
			halted_q <= halted_n;
		end
	end
endmodule
